@@ src/dek_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DIS event kinematics package
// Shared widths, codes, state and request types for the kinematics block.
// ----------------------------------------------------------------------------
package dek_pkg;

  localparam int FRAC_BITS = 16;

  localparam int MOM_W   = 24;               // momentum component
  localparam int CFG_W   = 24;               // widest config register
  localparam int CIDX_W  = 2;
  localparam int EB_W    = 24;
  localparam int TM_W    = 24;
  localparam int LM_W    = 16;               // light masses
  localparam int P2_W    = 50;               // |p|^2 plus a mass term
  localparam int E_W     = 25;               // root of P2_W bits
  localparam int NU_W    = 26;               // Eb - E before clamping
  localparam int EVNU_W  = 25;
  localparam int Q2_W    = 52 - FRAC_BITS;
  localparam int MN_W    = TM_W + E_W;
  localparam int MM_W    = 2 * TM_W;
  localparam int W2_W    = 54;
  localparam int Y_W     = 18;
  localparam int XB_W    = 25;
  localparam int PT_W    = 32;
  localparam int OUT24_W = 24;

  // shared unit
  localparam int ALU_W  = 80;                // accumulator / dividend
  localparam int DIV_W  = 52;                // divisor
  localparam int SQ_W   = 64;                // radicand
  localparam int MUL_IT = 26;                // multiplier bits per product
  localparam int CNT_W  = 7;

  localparam int YHI     = (1 << FRAC_BITS) > 131071 ? 131071 : (1 << FRAC_BITS);
  localparam int YLO_MAG = (1 << FRAC_BITS) > 131072 ? 131072 : (1 << FRAC_BITS);

  typedef enum logic [1:0] {
    OP_ELECTRON = 2'd0,
    OP_CLOSE    = 2'd1,
    OP_PION     = 2'd2,
    OP_NONE     = 2'd3
  } opcode_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_BEAM_ENERGY   = 2'd0,
    REG_TARGET_MASS   = 2'd1,
    REG_ELECTRON_MASS = 2'd2,
    REG_PION_MASS     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_MASS,
    ST_E_SQRT,
    ST_PMAG_SQRT,
    ST_Z_DIV,
    ST_Y_DIV,
    ST_EB_MUL,
    ST_N_MUL,
    ST_Q2_DIV,
    ST_MN_MUL,
    ST_MM_MUL,
    ST_XB_DIV,
    ST_W_SQRT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    alu_mode_e        mode;
    logic [ALU_W-1:0] opa;
    logic [DIV_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [ALU_W-1:0] res;
  } alu_rsp_t;

endpackage
`default_nettype wire

@@ src/dek_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DIS event kinematics stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dek_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [dek_pkg::MOM_W-1:0]  mom_x;
  logic signed [dek_pkg::MOM_W-1:0]  mom_y;
  logic signed [dek_pkg::MOM_W-1:0]  mom_z;

  modport source (output valid, opcode, mom_x, mom_y, mom_z, input ready);
  modport sink   (input valid, opcode, mom_x, mom_y, mom_z, output ready);
endinterface

interface dek_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic                                electron_found;
  logic signed [dek_pkg::OUT24_W-1:0]  energy_transfer;
  logic signed [dek_pkg::Y_W-1:0]      inelasticity;
  logic [31:0]                         momentum_transfer_sq;
  logic signed [dek_pkg::XB_W-1:0]     bjorken_x;
  logic [dek_pkg::OUT24_W-1:0]         invariant_mass;
  logic [dek_pkg::PT_W-1:0]            pion_pt_sq;
  logic [dek_pkg::OUT24_W-1:0]         energy_fraction;
  logic [1:0]                          flags;

  modport source (output valid, kind, electron_found, energy_transfer, inelasticity,
                  momentum_transfer_sq, bjorken_x, invariant_mass, pion_pt_sq,
                  energy_fraction, flags, input ready);
  modport sink   (input valid, kind, electron_found, energy_transfer, inelasticity,
                  momentum_transfer_sq, bjorken_x, invariant_mass, pion_pt_sq,
                  energy_fraction, flags, output ready);
endinterface
`default_nettype wire

@@ src/dis_event_kinematics.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DIS event kinematics
// Keeps the most energetic electron of an event, then computes nu, y, Q2,
// xB and W on close, and pT^2 and z for each pion, all through one shared
// multiply/divide/root unit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | beat contents
//  in_i     | in  | valid/ready   | opcode, mom_x, mom_y, mom_z
//  out_o    | out | valid/ready   | kind, electron_found, nu, y, Q2, xB, W,
//           |     |               | pT^2, z, flags
//  cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// One item at a time goes through the shared unit.
// rst_ni clears the event state and loads the default config.
// The output register lets a new item start while a result waits; the
// final step stalls until the output register is free.
// ----------------------------------------------------------------------------
module dis_event_kinematics (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dek_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [dek_pkg::CFG_W-1:0]  cfg_data_i,
  dek_in_if.sink                     in_i,
  dek_out_if.source                  out_o
);
  import dek_pkg::*;

  state_e   state_q, state_d;
  logic     pend_q, pend_d;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  state_e   nxt;
  logic     is_alu, fin_go, in_acc;

  logic [EB_W-1:0] eb_q;
  logic [TM_W-1:0] m_q;
  logic [LM_W-1:0] me_q, mpi_q;

  opcode_e                  op_q;
  logic [MOM_W-1:0]         ax_q, ay_q, az_q;
  logic signed [MOM_W-1:0]  pz_q;
  logic [P2_W-1:0]          p2_q;
  logic [PT_W-1:0]          pt_q;
  logic [ALU_W-1:0]         t_q;
  logic [E_W-1:0]           e_q;
  logic [E_W-1:0]           best_e_q, best_pmag_q;
  logic signed [MOM_W-1:0]  best_pz_q;
  logic                     have_q;
  logic signed [EVNU_W-1:0] ev_nu_q;
  logic                     ev_valid_q;
  logic signed [NU_W-1:0]   nu_q;
  logic [E_W-1:0]           anu_q;
  logic [Y_W-1:0]           y_q;
  logic [Q2_W-1:0]          q2_q;
  logic [MN_W-1:0]          mn_q;
  logic [MM_W-1:0]          mm_q;
  logic [OUT24_W-1:0]       xb_q, w_q, z_q;

  logic                      out_vld_q;
  logic                      o_kind_q, o_found_q;
  logic [OUT24_W-1:0]        o_nu_q, o_w_q, o_z_q;
  logic [Y_W-1:0]            o_y_q;
  logic [31:0]               o_q2_q;
  logic [XB_W-1:0]           o_xb_q;
  logic [PT_W-1:0]           o_pt_q;
  logic [1:0]                o_flags_q;

  logic signed [NU_W-1:0]    nu_w;
  logic [NU_W-1:0]           anu_w;
  logic [NU_W:0]             pdiff_w;
  logic [W2_W-1:0]           w2_w, tmn_w;
  logic                      nu_pos, w2_neg, ev_ok;
  logic [LM_W-1:0]           mass_w;
  logic [ALU_W-1:0]          sum_w;

  dek_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // ---------------- derived values ----------------
  assign nu_w    = $signed({2'b00, eb_q}) - $signed({1'b0, best_e_q});
  assign anu_w   = nu_w[NU_W-1] ? NU_W'(-nu_w) : NU_W'(nu_w);
  assign pdiff_w = {2'b00, best_pmag_q} - {{(NU_W+1-MOM_W){best_pz_q[MOM_W-1]}}, best_pz_q};
  assign nu_pos  = !nu_q[NU_W-1] && (nu_q != '0);
  assign tmn_w   = W2_W'(mn_q) << 1;
  assign w2_w    = W2_W'(mm_q) + (nu_q[NU_W-1] ? (W2_W'(0) - tmn_w) : tmn_w)
                   - (W2_W'(q2_q) << FRAC_BITS);
  assign w2_neg  = w2_w[W2_W-1];
  assign ev_ok   = ev_valid_q && !ev_nu_q[EVNU_W-1] && (ev_nu_q != '0);
  assign mass_w  = (op_q == OP_PION) ? mpi_q : me_q;
  assign sum_w   = ALU_W'(p2_q) + alu_rsp.res;
  assign in_acc  = in_i.valid && in_i.ready;
  assign fin_go  = (state_q == ST_FIN) && (!out_vld_q || out_o.ready);

  assign in_i.ready = (state_q == ST_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d       = state_q;
    pend_d        = pend_q;
    alu_req.start = 1'b0;
    alu_req.mode  = ALU_MUL;
    alu_req.opa   = '0;
    alu_req.opb   = '0;
    nxt           = ST_IDLE;
    is_alu        = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        is_alu = 1'b0;
        if (in_acc) begin
          unique case (opcode_e'(in_i.opcode))
            OP_ELECTRON, OP_PION: state_d = ST_SQ_X;
            OP_CLOSE:             state_d = have_q ? ST_Y_DIV : ST_FIN;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_SQ_X: begin
        alu_req.opa = ALU_W'(ax_q);
        alu_req.opb = DIV_W'(ax_q);
        nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        alu_req.opa = ALU_W'(ay_q);
        alu_req.opb = DIV_W'(ay_q);
        nxt = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        alu_req.opa = ALU_W'(az_q);
        alu_req.opb = DIV_W'(az_q);
        nxt = ST_MASS;
      end
      ST_MASS: begin
        alu_req.opa = ALU_W'(mass_w);
        alu_req.opb = DIV_W'(mass_w);
        nxt = ST_E_SQRT;
      end
      ST_E_SQRT: begin
        alu_req.mode = ALU_SQRT;
        alu_req.opa  = t_q;
        nxt = (op_q == OP_ELECTRON) ? ST_PMAG_SQRT : ST_Z_DIV;
      end
      ST_PMAG_SQRT: begin
        alu_req.mode = ALU_SQRT;
        alu_req.opa  = ALU_W'(p2_q);
        nxt = ST_IDLE;
      end
      ST_Z_DIV: begin
        alu_req.mode = ALU_DIV;
        alu_req.opa  = ALU_W'(e_q) << FRAC_BITS;
        alu_req.opb  = DIV_W'(unsigned'(ev_nu_q));
        nxt = ST_FIN;
      end
      ST_Y_DIV: begin
        alu_req.mode = ALU_DIV;
        alu_req.opa  = ALU_W'(anu_q) << FRAC_BITS;
        alu_req.opb  = DIV_W'(eb_q);
        nxt = ST_EB_MUL;
      end
      ST_EB_MUL: begin
        alu_req.opa = ALU_W'(best_e_q);
        alu_req.opb = DIV_W'(eb_q);
        nxt = ST_N_MUL;
      end
      ST_N_MUL: begin
        alu_req.opa = t_q << 1;
        alu_req.opb = DIV_W'(pdiff_w);
        nxt = ST_Q2_DIV;
      end
      ST_Q2_DIV: begin
        alu_req.mode = ALU_DIV;
        alu_req.opa  = t_q;
        alu_req.opb  = DIV_W'(best_pmag_q) << FRAC_BITS;
        nxt = ST_MN_MUL;
      end
      ST_MN_MUL: begin
        alu_req.opa = ALU_W'(m_q);
        alu_req.opb = DIV_W'(anu_q);
        nxt = ST_MM_MUL;
      end
      ST_MM_MUL: begin
        alu_req.opa = ALU_W'(m_q);
        alu_req.opb = DIV_W'(m_q);
        nxt = ST_XB_DIV;
      end
      ST_XB_DIV: begin
        alu_req.mode = ALU_DIV;
        alu_req.opa  = ALU_W'(q2_q) << (2 * FRAC_BITS);
        alu_req.opb  = DIV_W'(mn_q) << 1;
        nxt = ST_W_SQRT;
      end
      ST_W_SQRT: begin
        alu_req.mode = ALU_SQRT;
        alu_req.opa  = ALU_W'(w2_w);
        nxt = ST_FIN;
      end
      ST_FIN: begin
        is_alu = 1'b0;
        if (fin_go) state_d = ST_IDLE;
      end
      default: begin
        is_alu  = 1'b0;
        state_d = ST_IDLE;
      end
    endcase

    if (is_alu) begin
      if (!pend_q) begin
        alu_req.start = 1'b1;
        pend_d        = 1'b1;
      end
      if (alu_rsp.done) begin
        pend_d  = 1'b0;
        state_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // ---------------- config and event state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eb_q        <= EB_W'(694682);
      m_q         <= TM_W'(61490);
      me_q        <= LM_W'(33);
      mpi_q       <= LM_W'(9147);
      best_e_q    <= '0;
      best_pz_q   <= '0;
      best_pmag_q <= '0;
      have_q      <= 1'b0;
      ev_nu_q     <= '0;
      ev_valid_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BEAM_ENERGY:   eb_q  <= cfg_data_i[EB_W-1:0];
          REG_TARGET_MASS:   m_q   <= cfg_data_i[TM_W-1:0];
          REG_ELECTRON_MASS: me_q  <= cfg_data_i[LM_W-1:0];
          default:           mpi_q <= cfg_data_i[LM_W-1:0];
        endcase
      end

      // first candidate wins ties
      if (state_q == ST_PMAG_SQRT && alu_rsp.done && (!have_q || e_q > best_e_q)) begin
        best_e_q    <= e_q;
        best_pz_q   <= pz_q;
        best_pmag_q <= alu_rsp.res[E_W-1:0];
        have_q      <= 1'b1;
      end

      if (fin_go && op_q == OP_CLOSE) begin
        if (have_q) begin
          if (nu_q > $signed(NU_W'(24'hFF_FFFF)))       ev_nu_q <= EVNU_W'(25'h0FF_FFFF);
          else if (nu_q < -$signed(NU_W'(25'h100_0000))) ev_nu_q <= EVNU_W'(25'h100_0000);
          else                                          ev_nu_q <= nu_q[EVNU_W-1:0];
          ev_valid_q <= 1'b1;
        end else begin
          ev_nu_q    <= '0;
          ev_valid_q <= 1'b0;
        end
        have_q      <= 1'b0;
        best_e_q    <= '0;
        best_pz_q   <= '0;
        best_pmag_q <= '0;
      end

      if (fin_go)                         out_vld_q <= 1'b1;
      else if (out_vld_q && out_o.ready)  out_vld_q <= 1'b0;
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_e'(in_i.opcode);
      ax_q  <= in_i.mom_x[MOM_W-1] ? MOM_W'(-in_i.mom_x) : MOM_W'(in_i.mom_x);
      ay_q  <= in_i.mom_y[MOM_W-1] ? MOM_W'(-in_i.mom_y) : MOM_W'(in_i.mom_y);
      az_q  <= in_i.mom_z[MOM_W-1] ? MOM_W'(-in_i.mom_z) : MOM_W'(in_i.mom_z);
      pz_q  <= in_i.mom_z;
      nu_q  <= nu_w;
      anu_q <= anu_w[E_W-1:0];
    end

    if (alu_rsp.done) begin
      case (state_q)
        ST_SQ_X: p2_q <= alu_rsp.res[P2_W-1:0];
        ST_SQ_Y: begin
          p2_q <= sum_w[P2_W-1:0];
          if ((sum_w >> FRAC_BITS) > ALU_W'(32'hFFFF_FFFF)) pt_q <= '1;
          else pt_q <= PT_W'(sum_w >> FRAC_BITS);
        end
        ST_SQ_Z: p2_q <= sum_w[P2_W-1:0];
        ST_MASS: t_q <= sum_w;
        ST_E_SQRT: e_q <= alu_rsp.res[E_W-1:0];
        ST_Z_DIV: begin
          if (alu_rsp.res > ALU_W'(24'hFF_FFFF)) z_q <= '1;
          else z_q <= alu_rsp.res[OUT24_W-1:0];
        end
        ST_Y_DIV: begin
          if (eb_q == '0) begin
            y_q <= nu_q[NU_W-1] ? Y_W'(-YLO_MAG) : '0;
          end else if (nu_q[NU_W-1]) begin
            if (alu_rsp.res > ALU_W'(YLO_MAG)) y_q <= Y_W'(-YLO_MAG);
            else y_q <= Y_W'(0) - alu_rsp.res[Y_W-1:0];
          end else begin
            if (alu_rsp.res > ALU_W'(YHI)) y_q <= Y_W'(YHI);
            else y_q <= alu_rsp.res[Y_W-1:0];
          end
        end
        ST_EB_MUL, ST_N_MUL: t_q <= alu_rsp.res;
        ST_Q2_DIV: q2_q <= (best_pmag_q == '0) ? '0 : alu_rsp.res[Q2_W-1:0];
        ST_MN_MUL: mn_q <= alu_rsp.res[MN_W-1:0];
        ST_MM_MUL: mm_q <= alu_rsp.res[MM_W-1:0];
        ST_XB_DIV: begin
          if (!nu_pos)                             xb_q <= '0;
          else if (m_q == '0)                      xb_q <= (q2_q != '0) ? '1 : '0;
          else if (alu_rsp.res > ALU_W'(24'hFF_FFFF)) xb_q <= '1;
          else                                     xb_q <= alu_rsp.res[OUT24_W-1:0];
        end
        ST_W_SQRT: begin
          if (w2_neg)                                 w_q <= '0;
          else if (alu_rsp.res > ALU_W'(24'hFF_FFFF)) w_q <= '1;
          else                                        w_q <= alu_rsp.res[OUT24_W-1:0];
        end
        default: ;
      endcase
    end

    // result register
    if (fin_go) begin
      o_kind_q  <= (op_q == OP_PION);
      o_nu_q    <= '0;
      o_y_q     <= '0;
      o_q2_q    <= '0;
      o_xb_q    <= '0;
      o_w_q     <= '0;
      o_pt_q    <= '0;
      o_z_q     <= '0;
      o_flags_q <= '0;
      o_found_q <= 1'b0;
      if (op_q == OP_PION) begin
        o_found_q <= ev_valid_q;
        o_pt_q    <= pt_q;
        o_z_q     <= ev_ok ? z_q : '0;
        o_flags_q <= {1'b0, !ev_ok};
      end else if (have_q) begin
        o_found_q <= 1'b1;
        if (nu_q > $signed(NU_W'(24'h7F_FFFF)))       o_nu_q <= OUT24_W'(24'h7F_FFFF);
        else if (nu_q < -$signed(NU_W'(24'h80_0000))) o_nu_q <= OUT24_W'(24'h80_0000);
        else                                          o_nu_q <= nu_q[OUT24_W-1:0];
        o_y_q     <= y_q;
        o_q2_q    <= (64'(q2_q) > 64'(32'hFFFF_FFFF)) ? '1 : 32'(q2_q);
        o_xb_q    <= XB_W'(xb_q);
        o_w_q     <= w_q;
        o_flags_q <= {w2_neg, !nu_pos};
      end
    end
  end

  assign out_o.valid                = out_vld_q;
  assign out_o.kind                 = o_kind_q;
  assign out_o.electron_found       = o_found_q;
  assign out_o.energy_transfer      = o_nu_q;
  assign out_o.inelasticity         = o_y_q;
  assign out_o.momentum_transfer_sq = o_q2_q;
  assign out_o.bjorken_x            = o_xb_q;
  assign out_o.invariant_mass       = o_w_q;
  assign out_o.pion_pt_sq           = o_pt_q;
  assign out_o.energy_fraction      = o_z_q;
  assign out_o.flags                = o_flags_q;

  // ---------------- assertions ----------------
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_i.ready)
    else $error("input ready while shared unit busy");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> pend_q)
    else $error("shared unit done without a request");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FIN))
    else $error("result loaded outside final step");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && op_q == OP_CLOSE) |=> !have_q)
    else $error("electron candidate kept across close");

endmodule
`default_nettype wire

@@ src/dek_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DIS event kinematics shared arithmetic unit
// Bit-serial multiply, restoring divide and digit-by-digit square root
// around one compare/subtract and one adder.
// ----------------------------------------------------------------------------
module dek_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dek_pkg::alu_req_t req_i,
  output dek_pkg::alu_rsp_t rsp_o
);
  import dek_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  alu_mode_e        mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ALU_W-1:0] acc_q, acc_d;
  logic [ALU_W-1:0] sh_q, sh_d;
  logic [DIV_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] b_q, b_d;
  logic [DIV_W:0]   part, sub, diff;
  logic             fits;

  always_comb begin
    busy_d = busy_q;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    b_d    = b_q;
    done_d = 1'b0;

    // divide brings in one dividend bit, root two radicand bits
    if (mode_q == ALU_DIV) begin
      part = {rem_q[DIV_W-1:0], sh_q[ALU_W-1]};
      sub  = {1'b0, b_q};
    end else begin
      part = {rem_q[DIV_W-2:0], sh_q[ALU_W-1 -: 2]};
      sub  = {acc_q[DIV_W-2:0], 2'b01};
    end
    diff = part - sub;
    fits = (part >= sub);

    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      acc_d  = '0;
      rem_d  = '0;
      b_d    = req_i.opb;
      unique case (req_i.mode)
        ALU_MUL: begin
          sh_d  = req_i.opa;
          cnt_d = CNT_W'(MUL_IT - 1);
        end
        ALU_DIV: begin
          sh_d  = req_i.opa;
          cnt_d = CNT_W'(ALU_W - 1);
        end
        default: begin
          sh_d  = {req_i.opa[SQ_W-1:0], {(ALU_W-SQ_W){1'b0}}};
          cnt_d = CNT_W'(SQ_W / 2 - 1);
        end
      endcase
    end else if (busy_q) begin
      unique case (mode_q)
        ALU_MUL: begin
          if (b_q[0]) acc_d = acc_q + sh_q;
          sh_d = sh_q << 1;
          b_d  = b_q >> 1;
        end
        ALU_DIV: begin
          rem_d = fits ? diff : part;
          acc_d = {acc_q[ALU_W-2:0], fits};
          sh_d  = sh_q << 1;
        end
        default: begin
          rem_d = fits ? diff : part;
          acc_d = {acc_q[ALU_W-2:0], fits};
          sh_d  = sh_q << 2;
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = acc_q;

endmodule
`default_nettype wire
